// ===== src/periodic_task_timer_table_top_macros.svh =====
// Assertion macros used by the timer table checker.
`ifndef PERIODIC_TASK_TIMER_TABLE_TOP_MACROS_SVH
`define PERIODIC_TASK_TIMER_TABLE_TOP_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define PTT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset-qualified.
`define PTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ptt_pkg.sv =====
// Types and codes shared by the timer table modules.
package ptt_pkg;

    localparam int PERIOD_W = 24;
    localparam int IDENT_W  = 16;
    localparam int ACTION_W = 2;
    localparam int KIND_W   = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [ACTION_W-1:0] ACT_SCHEDULE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CANCEL   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd2;

    localparam logic [KIND_W-1:0] KIND_SCHEDULED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NO_ID     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DUE       = 3'd4;
    localparam logic [KIND_W-1:0] KIND_IDLE      = 3'd5;

    // One classified command on its way from front to back.
    typedef struct packed {
        logic [ACTION_W-1:0] op;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] delay;
        logic [IDENT_W-1:0]  target;
    } cmd_t;

endpackage

// ===== src/ptt_front.sv =====
// Front end: accepts input transfers, drops unused actions, queues commands.
module ptt_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ptt_pkg::ACTION_W-1:0]  in_action,
    input  logic [ptt_pkg::PERIOD_W-1:0]  in_period,
    input  logic [ptt_pkg::PERIOD_W-1:0]  in_delay,
    input  logic [ptt_pkg::IDENT_W-1:0]   in_target,
    output logic                          cmd_valid,
    output ptt_pkg::cmd_t                 cmd,
    input  logic                          cmd_pop
);

    ptt_pkg::cmd_t q_reg [ptt_pkg::QUEUE_DEPTH];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    fill_reg, fill_next;
    logic          keep;
    logic          push;
    ptt_pkg::cmd_t in_cmd;

    always_comb
    begin
        case (in_action)
            ptt_pkg::ACT_SCHEDULE: keep = 1'b1;
            ptt_pkg::ACT_CANCEL:   keep = 1'b1;
            ptt_pkg::ACT_TICK:     keep = 1'b1;
            default:               keep = 1'b0;
        endcase
    end

    assign in_ready  = (fill_reg != 2'(ptt_pkg::QUEUE_DEPTH));
    assign push      = in_valid && in_ready && keep;
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    assign in_cmd.op     = in_action;
    assign in_cmd.period = in_period;
    assign in_cmd.delay  = in_delay;
    assign in_cmd.target = in_target;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== src/ptt_back.sv =====
// Back end: timer table, sweep engine and output register.
module ptt_back
#(
    parameter int TABLE_DEPTH = 16,
    parameter int TIME_BITS   = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    input  ptt_pkg::cmd_t                cmd,
    output logic                         cmd_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ptt_pkg::KIND_W-1:0]   out_kind,
    output logic [ptt_pkg::IDENT_W-1:0]  out_id,
    output logic                         out_last
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int EXT_W = (TIME_BITS > ptt_pkg::PERIOD_W) ? TIME_BITS : ptt_pkg::PERIOD_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // table storage, slots 0..count-1 valid in insertion order
    logic [ptt_pkg::IDENT_W-1:0]  ident_mem  [TABLE_DEPTH];
    logic [ptt_pkg::PERIOD_W-1:0] period_mem [TABLE_DEPTH];
    logic [TIME_BITS-1:0]         due_mem    [TABLE_DEPTH];

    logic [1:0]                   state_reg, state_next;
    logic [ptt_pkg::ACTION_W-1:0] op_reg, op_next;
    logic [ptt_pkg::IDENT_W-1:0]  target_reg, target_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [CNT_W-1:0]             rptr_reg, rptr_next;
    logic [CNT_W-1:0]             wptr_reg, wptr_next;
    logic                         found_reg, found_next;
    logic                         hold_valid_reg, hold_valid_next;
    logic [ptt_pkg::IDENT_W-1:0]  hold_id_reg, hold_id_next;
    logic                         proc_valid_reg, proc_valid_next;
    logic [TIME_BITS-1:0]         time_reg, time_next;
    logic [ptt_pkg::IDENT_W-1:0]  next_id_reg, next_id_next;
    logic                         out_valid_reg, out_valid_next;
    logic [ptt_pkg::KIND_W-1:0]   out_kind_reg, out_kind_next;
    logic [ptt_pkg::IDENT_W-1:0]  out_id_reg, out_id_next;
    logic                         out_last_reg, out_last_next;

    logic [ptt_pkg::IDENT_W-1:0]  rd_ident_reg;
    logic [ptt_pkg::PERIOD_W-1:0] rd_period_reg;
    logic [TIME_BITS-1:0]         rd_due_reg;

    logic                         mem_we;
    logic [IDX_W-1:0]             mem_waddr;
    logic [ptt_pkg::IDENT_W-1:0]  mem_wident;
    logic [ptt_pkg::PERIOD_W-1:0] mem_wperiod;
    logic [TIME_BITS-1:0]         mem_wdue;

    logic                         out_free;
    logic                         out_load;
    logic [TIME_BITS-1:0]         age;
    logic                         slot_due;
    logic [TIME_BITS-1:0]         rearm_due;
    logic [TIME_BITS-1:0]         sched_due;
    logic                         tick_op;
    logic                         match;
    logic                         stall;
    logic                         proc_go;
    logic                         issue;
    logic [ptt_pkg::IDENT_W-1:0]  id_inc;

    assign out_free  = !out_valid_reg || out_ready;
    assign age       = time_reg - rd_due_reg;
    assign slot_due  = !age[TIME_BITS-1];
    assign rearm_due = TIME_BITS'(EXT_W'(time_reg) + EXT_W'(rd_period_reg));
    assign sched_due = TIME_BITS'(EXT_W'(time_reg) + EXT_W'(cmd.delay));
    assign tick_op   = (op_reg == ptt_pkg::ACT_TICK);
    assign match     = !found_reg && (rd_ident_reg == target_reg);
    // a second due entry pushes the held one out; that needs the output free
    assign stall     = proc_valid_reg && tick_op && slot_due && hold_valid_reg && !out_free;
    assign proc_go   = proc_valid_reg && !stall;
    assign issue     = (state_reg == ST_SCAN) && (rptr_reg < count_reg) && !stall;
    assign id_inc    = next_id_reg + 16'd1;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        target_next     = target_reg;
        count_next      = count_reg;
        rptr_next       = rptr_reg;
        wptr_next       = wptr_reg;
        found_next      = found_reg;
        hold_valid_next = hold_valid_reg;
        hold_id_next    = hold_id_reg;
        proc_valid_next = proc_valid_reg;
        time_next       = time_reg;
        next_id_next    = next_id_reg;
        out_load        = 1'b0;
        out_kind_next   = out_kind_reg;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;
        cmd_pop         = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = wptr_reg[IDX_W-1:0];
        mem_wident      = rd_ident_reg;
        mem_wperiod     = rd_period_reg;
        mem_wdue        = rd_due_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        ptt_pkg::ACT_SCHEDULE:
                        begin
                            if (out_free)
                            begin
                                cmd_pop       = 1'b1;
                                out_load      = 1'b1;
                                out_last_next = 1'b1;
                                if (count_reg == CNT_W'(TABLE_DEPTH))
                                begin
                                    out_kind_next = ptt_pkg::KIND_FULL;
                                    out_id_next   = '0;
                                end
                                else
                                begin
                                    mem_we        = 1'b1;
                                    mem_waddr     = count_reg[IDX_W-1:0];
                                    mem_wident    = next_id_reg;
                                    mem_wperiod   = cmd.period;
                                    mem_wdue      = sched_due;
                                    out_kind_next = ptt_pkg::KIND_SCHEDULED;
                                    out_id_next   = next_id_reg;
                                    count_next    = count_reg + CNT_W'(1);
                                    next_id_next  = (id_inc == '0) ? 16'd1 : id_inc;
                                end
                            end
                        end
                        ptt_pkg::ACT_CANCEL, ptt_pkg::ACT_TICK:
                        begin
                            cmd_pop         = 1'b1;
                            op_next         = cmd.op;
                            target_next     = cmd.target;
                            rptr_next       = '0;
                            wptr_next       = '0;
                            found_next      = 1'b0;
                            hold_valid_next = 1'b0;
                            state_next      = ST_SCAN;
                            if (cmd.op == ptt_pkg::ACT_TICK)
                            begin
                                time_next = time_reg + TIME_BITS'(1);
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (issue)
                begin
                    rptr_next = rptr_reg + CNT_W'(1);
                end
                if (!stall)
                begin
                    proc_valid_next = issue;
                end
                if (proc_go)
                begin
                    if (tick_op)
                    begin
                        if (slot_due)
                        begin
                            if (hold_valid_reg)
                            begin
                                out_load      = 1'b1;
                                out_kind_next = ptt_pkg::KIND_DUE;
                                out_id_next   = hold_id_reg;
                                out_last_next = 1'b0;
                            end
                            hold_valid_next = 1'b1;
                            hold_id_next    = rd_ident_reg;
                            // one-shot entries are dropped by not copying them down
                            if (rd_period_reg != '0)
                            begin
                                mem_we    = 1'b1;
                                mem_wdue  = rearm_due;
                                wptr_next = wptr_reg + CNT_W'(1);
                            end
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            wptr_next = wptr_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        if (match)
                        begin
                            found_next = 1'b1;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            wptr_next = wptr_reg + CNT_W'(1);
                        end
                    end
                end
                if (!proc_valid_reg && (rptr_reg == count_reg))
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_last_next = 1'b1;
                    count_next    = wptr_reg;
                    state_next    = ST_IDLE;
                    if (tick_op)
                    begin
                        out_kind_next = hold_valid_reg ? ptt_pkg::KIND_DUE : ptt_pkg::KIND_IDLE;
                        out_id_next   = hold_valid_reg ? hold_id_reg : '0;
                    end
                    else
                    begin
                        out_kind_next = found_reg ? ptt_pkg::KIND_CANCELLED
                                                  : ptt_pkg::KIND_NO_ID;
                        out_id_next   = found_reg ? target_reg : '0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= ptt_pkg::ACT_SCHEDULE;
            count_reg      <= '0;
            rptr_reg       <= '0;
            wptr_reg       <= '0;
            found_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
            proc_valid_reg <= 1'b0;
            time_reg       <= '0;
            next_id_reg    <= 16'd1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            count_reg      <= count_next;
            rptr_reg       <= rptr_next;
            wptr_reg       <= wptr_next;
            found_reg      <= found_next;
            hold_valid_reg <= hold_valid_next;
            proc_valid_reg <= proc_valid_next;
            time_reg       <= time_next;
            next_id_reg    <= next_id_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg   <= target_next;
        hold_id_reg  <= hold_id_next;
        out_kind_reg <= out_kind_next;
        out_id_reg   <= out_id_next;
        out_last_reg <= out_last_next;
    end

    // table write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ident_mem[mem_waddr]  <= mem_wident;
            period_mem[mem_waddr] <= mem_wperiod;
            due_mem[mem_waddr]    <= mem_wdue;
        end
    end

    // table read port, data registered
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_ident_reg  <= ident_mem[rptr_reg[IDX_W-1:0]];
            rd_period_reg <= period_mem[rptr_reg[IDX_W-1:0]];
            rd_due_reg    <= due_mem[rptr_reg[IDX_W-1:0]];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_id    = out_id_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== src/periodic_task_timer_table_top.sv =====
// Top level of the periodic and one-shot timer table.
// Schedule: result through the front queue and output register; one per cycle while not stalled.
// Cancel and tick: a sweep reads the N live entries (at most TABLE_DEPTH) in turn through
// the single read port of the table, then gives the final result.
// Tick due results leave as found, the last held back to carry tlast.
// Reset (rst_n low, asynchronous) empties the table via its fill count, sets time 0, next id 1.
module periodic_task_timer_table_top
#(
    parameter int TABLE_DEPTH = 16,
    parameter int TIME_BITS   = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [23:0] period_ticks, [47:24] delay_ticks, [63:48] target_id
    input  logic [1:0]  s_tuser,    // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] entry_id
    output logic [2:0]  m_tuser,    // [2:0] kind
    output logic        m_tlast
);

    logic          cmd_valid;
    ptt_pkg::cmd_t cmd;
    logic          cmd_pop;

    // Front end: takes every input transfer it has room for, drops the unused
    // action code, and keeps up to two commands so the next item can be taken
    // while the table sweep is still running.
    ptt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_period (s_tdata[23:0]),
        .in_delay  (s_tdata[47:24]),
        .in_target (s_tdata[63:48]),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Back end: the table is kept packed in insertion order. Cancel and tick
    // walk it with a read pointer and a write pointer; removed entries are
    // simply not copied down, so the fill count shrinks at the end of the walk.
    // Times compare wrap-safe through the sign bit of (now - due).
    ptt_back
    #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_id    (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// ===== src/ptt_checker.sv =====
// Port-level checks on the timer table result stream, with its bind.
`include "periodic_task_timer_table_top_macros.svh"

module ptt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    logic        stalled;
    logic [19:0] beat;
    logic        lone;
    logic        idless;
    logic        idful;

    assign stalled = m_tvalid && !m_tready;
    assign beat    = {m_tlast, m_tuser, m_tdata};
    assign lone    = m_tvalid && (m_tuser != ptt_pkg::KIND_DUE);
    assign idless  = m_tvalid && ((m_tuser == ptt_pkg::KIND_FULL)
                                  || (m_tuser == ptt_pkg::KIND_NO_ID)
                                  || (m_tuser == ptt_pkg::KIND_IDLE));
    assign idful   = m_tvalid && ((m_tuser == ptt_pkg::KIND_SCHEDULED)
                                  || (m_tuser == ptt_pkg::KIND_CANCELLED)
                                  || (m_tuser == ptt_pkg::KIND_DUE));

    // stalled result holds
    `PTT_ASSERT_NEXT(a_hold, clk, rst_n, stalled, m_tvalid && $stable(beat), "held result changed")

    // only due results may come without tlast
    `PTT_ASSERT_NOW(a_single_last, clk, rst_n, lone, m_tlast, "single result without tlast")

    // kinds without an entry carry id zero
    `PTT_ASSERT_NOW(a_zero_id, clk, rst_n, idless, m_tdata == 16'd0, "id on idless result")

    // ids handed out are never zero
    `PTT_ASSERT_NOW(a_live_id, clk, rst_n, idful, m_tdata != 16'd0, "zero entry id")

endmodule

bind periodic_task_timer_table_top ptt_checker u_ptt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the periodic and one-shot timer table.
module tb_top;
    import ptt_pkg::*;

    localparam int SLOTS = 16;
    localparam int TIME_W = 32;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [PERIOD_W-1:0] SPAN_MAX = '1;
    localparam logic [IDENT_W-1:0] IDENT_MAX = '1;
    localparam int IDLE_PCT = 23;
    localparam int RANDOM_ITEMS = 325;
    localparam int PAUSE_AT = 160;
    localparam int STEADY_FROM = 200;
    localparam int STEADY_TO = 270;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int REPORT_CAP = 100;

    // One command as queued for the stream, plus flow hints for the driver.
    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] delay;
        logic [IDENT_W-1:0]  target;
        bit                  drain_first;   // hold off until all owed results are in
        bit                  steady;        // no idling on either side
    } timer_cmd_t;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [IDENT_W-1:0] ident;
        logic               last;
    } timer_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [63:0]         s_tdata = '0;      // [23:0] period, [47:24] delay, [63:48] target id
    logic [ACTION_W-1:0] s_tuser = '0;      // [1:0] action
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [15:0]         m_tdata;           // [15:0] entry id
    logic [KIND_W-1:0]   m_tuser;           // [2:0] kind
    logic                m_tlast;

    timer_cmd_t    cmd_backlog[$];
    timer_cmd_t    on_bus;
    timer_result_t owed_results[$];
    bit            steady = 1'b0;
    int            mismatches = 0;
    int            gen_ident = 1;           // id the next schedule should get, roughly

    // Shadow of the timer table
    bit                  slot_live   [SLOTS];
    logic [IDENT_W-1:0]  slot_ident  [SLOTS];
    logic [PERIOD_W-1:0] slot_period [SLOTS];
    logic [TIME_W-1:0]   slot_due    [SLOTS];
    logic [TIME_W-1:0]   now_ticks;
    logic [IDENT_W-1:0]  ident_next;

    periodic_task_timer_table_top #(
        .TABLE_DEPTH(SLOTS),
        .TIME_BITS  (TIME_W)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial forever #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Table prediction
    // ---------------------------------------------------------------

    // Remove one slot; later entries move down to keep insertion order.
    task automatic drop_slot(input int s);
        for (int j = s; j < SLOTS - 1; j++)
        begin
            slot_live[j]   = slot_live[j + 1];
            slot_ident[j]  = slot_ident[j + 1];
            slot_period[j] = slot_period[j + 1];
            slot_due[j]    = slot_due[j + 1];
        end
        slot_live[SLOTS - 1]   = 1'b0;
        slot_ident[SLOTS - 1]  = '0;
        slot_period[SLOTS - 1] = '0;
        slot_due[SLOTS - 1]    = '0;
    endtask

    task automatic owe(input logic [KIND_W-1:0] kind, input logic [IDENT_W-1:0] ident,
                       input logic last);
        timer_result_t r;
        r.kind  = kind;
        r.ident = ident;
        r.last  = last;
        owed_results.insert(owed_results.size(), r);
    endtask

    // Apply one accepted command to the shadow table, owing its results.
    task automatic table_apply(input timer_cmd_t c);
        int                 i;
        int                 hits;
        logic [TIME_W-1:0]  lag;
        case (c.action)
            ACT_SCHEDULE:
            begin
                i = 0;
                while (i < SLOTS && slot_live[i])
                    i++;
                if (i == SLOTS)
                    owe(KIND_FULL, '0, 1'b1);     // id does not advance
                else
                begin
                    slot_live[i]   = 1'b1;
                    slot_ident[i]  = ident_next;
                    slot_period[i] = c.period;
                    slot_due[i]    = now_ticks + TIME_W'(c.delay);
                    owe(KIND_SCHEDULED, ident_next, 1'b1);
                    ident_next = ident_next + 1'b1;
                    if (ident_next == '0)
                        ident_next = IDENT_W'(1);
                end
            end
            ACT_CANCEL:
            begin
                // first match in table order only
                i = 0;
                while (i < SLOTS && !(slot_live[i] && slot_ident[i] == c.target))
                    i++;
                if (i == SLOTS)
                    owe(KIND_NO_ID, '0, 1'b1);
                else
                begin
                    drop_slot(i);
                    owe(KIND_CANCELLED, c.target, 1'b1);
                end
            end
            ACT_TICK:
            begin
                now_ticks = now_ticks + 1'b1;
                hits = 0;
                i = 0;
                while (i < SLOTS && slot_live[i])
                begin
                    // due once now has reached due, modulo the time width
                    lag = now_ticks - slot_due[i];
                    if (!lag[TIME_W-1])
                    begin
                        owe(KIND_DUE, slot_ident[i], 1'b0);
                        hits++;
                        if (slot_period[i] == '0)
                        begin
                            drop_slot(i);
                            continue;
                        end
                        slot_due[i] = now_ticks + TIME_W'(slot_period[i]);
                    end
                    i++;
                end
                if (hits == 0)
                    owe(KIND_IDLE, '0, 1'b1);
                else
                    owed_results[owed_results.size() - 1].last = 1'b1;
            end
            default: ;      // unused action: ignored, no result
        endcase
    endtask

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    task automatic queue_cmd(input logic [ACTION_W-1:0] action,
                             input logic [PERIOD_W-1:0] period,
                             input logic [PERIOD_W-1:0] delay,
                             input logic [IDENT_W-1:0]  target,
                             input bit drain_first, input bit steady_flow);
        timer_cmd_t c;
        c.action      = action;
        c.period      = period;
        c.delay       = delay;
        c.target      = target;
        c.drain_first = drain_first;
        c.steady      = steady_flow;
        cmd_backlog.insert(cmd_backlog.size(), c);
        if (action == ACT_SCHEDULE)
        begin
            gen_ident = (gen_ident + 1) & IDENT_MAX;
            if (gen_ident == 0)
                gen_ident = 1;
        end
    endtask

    // Mostly one-shot or short periods; now and then a huge one.
    function automatic logic [PERIOD_W-1:0] pick_period();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return '0;
        if (roll < 97)
            return PERIOD_W'($urandom_range(1, 8));
        return PERIOD_W'($urandom);
    endfunction

    function automatic logic [PERIOD_W-1:0] pick_delay();
        int roll;
        roll = $urandom_range(99);
        if (roll < 85)
            return PERIOD_W'($urandom_range(0, 6));
        if (roll < 98)
            return PERIOD_W'($urandom_range(7, 40));
        return PERIOD_W'($urandom);
    endfunction

    // Mostly recently issued ids, so cancels hit; otherwise misses.
    function automatic logic [IDENT_W-1:0] pick_target();
        int roll;
        roll = $urandom_range(99);
        if (roll < 75)
            return IDENT_W'(gen_ident - $urandom_range(1, 24));
        if (roll < 90)
            return IDENT_W'($urandom);
        if (roll < 95)
            return '0;
        return IDENT_MAX;
    endfunction

    task automatic report_field(input string name, input logic [IDENT_W-1:0] want,
                                input logic [IDENT_W-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    endtask

    // ---------------------------------------------------------------
    // Driver: one command on the slave side, refilled as transfers complete
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : feed
        timer_cmd_t nxt;
        bit         load;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            steady   <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                table_apply(on_bus);
            if (!s_tvalid || s_tready)
            begin
                load = 1'b0;
                if (cmd_backlog.size() != 0)
                begin
                    nxt = cmd_backlog[0];
                    load = (nxt.steady || $urandom_range(99) >= IDLE_PCT)
                        && (!nxt.drain_first || owed_results.size() == 0);
                end
                if (load)
                begin
                    void'(cmd_backlog.pop_front());
                    on_bus = nxt;
                    s_tdata <= {nxt.target, nxt.delay, nxt.period};
                    s_tuser <= nxt.action;
                    steady  <= nxt.steady;
                end
                s_tvalid <= load;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: check each master-side transfer against the oldest owed result
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : sink
        timer_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (owed_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t: result with none expected, actual kind %0d id %0h last %0b",
                                 $time, m_tuser, m_tdata, m_tlast);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (m_tuser !== want.kind)
                        report_field("kind", IDENT_W'(want.kind), IDENT_W'(m_tuser));
                    if (m_tdata !== want.ident)
                        report_field("entry_id", want.ident, m_tdata);
                    if (m_tlast !== want.last)
                        report_field("last", IDENT_W'(want.last), IDENT_W'(m_tlast));
                end
            end
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus, reset and end of run
    // ---------------------------------------------------------------
    initial
    begin : main
        int issued;
        int pick;
        int cycles;
        bit timed_out;
        bit calm;

        // Directed part, table empty, next id 1.
        queue_cmd(ACT_TICK, '0, '0, '0, 1'b1, 1'b0);               // idle tick
        queue_cmd(ACT_SCHEDULE, '0, '0, '0, 1'b0, 1'b0);           // one-shot, due next tick
        queue_cmd(ACT_SCHEDULE, SPAN_MAX, SPAN_MAX, '0, 1'b0, 1'b0);
        queue_cmd(ACT_SCHEDULE, 24'd1, 24'd1, '0, 1'b0, 1'b0);     // shortest period
        queue_cmd(ACT_SCHEDULE, 24'd2, '0, '0, 1'b0, 1'b0);
        queue_cmd(ACT_TICK, '0, '0, '0, 1'b0, 1'b0);               // several due at once
        queue_cmd(ACT_CANCEL, '0, '0, 16'd4, 1'b0, 1'b0);
        queue_cmd(ACT_CANCEL, '0, '0, '0, 1'b0, 1'b0);             // unknown id
        queue_cmd(ACT_CANCEL, '0, '0, IDENT_MAX, 1'b0, 1'b0);      // unknown id
        queue_cmd(ACT_UNUSED, SPAN_MAX, SPAN_MAX, IDENT_MAX, 1'b0, 1'b0);
        queue_cmd(ACT_CANCEL, '0, '0, 16'd5, 1'b0, 1'b0);
        // Fill the table, then two schedules past full
        repeat (SLOTS)
            queue_cmd(ACT_SCHEDULE, PERIOD_W'($urandom_range(0, 4)),
                      PERIOD_W'($urandom_range(0, 3)), '0, 1'b0, 1'b0);

        // Random part: well-formed commands with random content; unused actions
        // mixed in but not counted. One stretch runs with no idling at all.
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            calm = (issued >= STEADY_FROM) && (issued < STEADY_TO);
            if (pick < 38)
                queue_cmd(ACT_SCHEDULE, pick_period(), pick_delay(), IDENT_W'($urandom),
                          issued == PAUSE_AT, calm);
            else if (pick < 58)
                queue_cmd(ACT_CANCEL, PERIOD_W'($urandom), PERIOD_W'($urandom), pick_target(),
                          issued == PAUSE_AT, calm);
            else if (pick < 96)
                queue_cmd(ACT_TICK, PERIOD_W'($urandom), PERIOD_W'($urandom),
                          IDENT_W'($urandom), issued == PAUSE_AT, calm);
            else
            begin
                queue_cmd(ACT_UNUSED, PERIOD_W'($urandom), PERIOD_W'($urandom),
                          IDENT_W'($urandom), 1'b0, calm);
                continue;
            end
            issued++;
        end

        // Shadow table after reset
        for (int s = 0; s < SLOTS; s++)
        begin
            slot_live[s]   = 1'b0;
            slot_ident[s]  = '0;
            slot_period[s] = '0;
            slot_due[s]    = '0;
        end
        now_ticks  = '0;
        ident_next = IDENT_W'(1);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        cycles = 0;
        while (!(cmd_backlog.size() == 0 && !s_tvalid && owed_results.size() == 0)
               && cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        timed_out = (cycles >= CYCLE_LIMIT);
        if (timed_out)
            $display("%0t: timeout, %0d results still expected", $time, owed_results.size());
        else
            repeat (SETTLE_CYCLES) @(posedge clk);

        if (!timed_out && mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/ptt_pkg.sv
src/ptt_front.sv
src/ptt_back.sv
src/periodic_task_timer_table_top.sv
src/ptt_checker.sv
tb/sv/tb_top.sv
